// File: hw/rtl/assert_macros.svh
// assertion helpers used by range_value_replace_blocked_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define RVR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition that must never be true outside reset
`define RVR_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/rvr_pkg.sv
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared constants and types of the blocked range value replace unit.
// ----------------------------------------------------------------------------
package rvr_pkg;

   localparam int IDX_W = 12;
   localparam int VAL_W = 7;
   localparam int OFS_W = 6;
   localparam int BLK_W = IDX_W - OFS_W;
   localparam int NUM_ELEMS = 1 << IDX_W;
   localparam int NUM_BLOCKS = 1 << BLK_W;
   localparam int RMP_DEPTH = NUM_BLOCKS << VAL_W;

   localparam logic [VAL_W-1:0] MAX_VAL = 7'd100;
   localparam logic [OFS_W-1:0] LAST_OFS = {OFS_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_REPLACE = 2'd1,
      KIND_READ    = 2'd2
   } kind_type;

   // access request from the sequencer to the remap store
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             set_valid;
      logic             clear_valid;
      logic [BLK_W-1:0] blk;
      logic [VAL_W-1:0] ent;
      logic [VAL_W-1:0] wdata;
   } rmp_req_type;

endpackage

// File: hw/rtl/rvr_req_if.sv
// ----------------------------------------------------------------------------
// rvr_req_if
// Request channel: one load, range replace or read item per transfer.
// ----------------------------------------------------------------------------
interface rvr_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic [11:0]             first_index;
   logic [11:0]             last_index;
   logic [6:0]              match_value;
   logic [6:0]              new_value;

   modport source (output valid, kind, first_index, last_index, match_value, new_value,
                   input ready);
   modport sink   (input valid, kind, first_index, last_index, match_value, new_value,
                   output ready);
endinterface

// File: hw/rtl/rvr_rsp_if.sv
// ----------------------------------------------------------------------------
// rvr_rsp_if
// Response channel: one element value per transfer.
// ----------------------------------------------------------------------------
interface rvr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] read_index;
   logic [6:0]  read_value;

   modport source (output valid, read_index, read_value, input ready);
   modport sink   (input valid, read_index, read_value, output ready);
endinterface

// File: hw/rtl/rvr_remap_store.sv
// ----------------------------------------------------------------------------
// rvr_remap_store
// Per-block remap tables in one synchronous memory, with a valid bit per
// block; a block without its valid bit reads as the identity map.
// ----------------------------------------------------------------------------
module rvr_remap_store (
   input  logic                       clock,
   input  logic                       reset,
   input  rvr_pkg::rmp_req_type       req,
   output logic [rvr_pkg::VAL_W-1:0]  rd_data
);
   import rvr_pkg::*;

   logic [VAL_W-1:0]      mem [RMP_DEPTH];
   logic [VAL_W-1:0]      mem_q_ff;
   logic [VAL_W-1:0]      ent_q_ff;
   logic                  valid_q_ff;
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [NUM_BLOCKS-1:0] valid_in;

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[{req.blk, req.ent}] <= req.wdata;
      end
      if (req.rd_en) begin
         mem_q_ff   <= mem[{req.blk, req.ent}];
         ent_q_ff   <= req.ent;
         valid_q_ff <= valid_ff[req.blk];
      end
   end

   // block valid bits
   always_comb begin
      valid_in = valid_ff;
      if (req.set_valid) begin
         valid_in[req.blk] = 1'b1;
      end
      if (req.clear_valid) begin
         valid_in[req.blk] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // identity when the table was never written since the last flush
   assign rd_data = valid_q_ff ? mem_q_ff : ent_q_ff;

endmodule

// File: hw/rtl/range_value_replace_blocked_unit.sv
// ----------------------------------------------------------------------------
// range_value_replace_blocked_unit
// Blocked array of small values with lazy per-block remap tables.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer over two one-port memories
// (4096 elements, 64 remap tables). A read reads the element memory on its
// transfer, looks the value up in its block's remap table in S_R_MAP and
// registers its result in S_R_OUT; it waits in S_R_OUT while an earlier
// result is still held on the result channel. A load with a valid value
// flushes its block element by element. A range replace rewrites the remap
// table of each block strictly inside the range entry by entry, and flushes
// each edge block element by element. Invalid items are accepted and dropped
// in S_IDLE. No clearing pass is needed after reset.
`include "assert_macros.svh"

module range_value_replace_blocked_unit (
   input  logic    clock,
   input  logic    reset,
   rvr_req_if.sink   req_chan,
   rvr_rsp_if.source rsp_chan
);
   import rvr_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_E_RD  = 8'b0000_0010,
      S_E_MAP = 8'b0000_0100,
      S_E_WR  = 8'b0000_1000,
      S_B_RD  = 8'b0001_0000,
      S_B_WR  = 8'b0010_0000,
      S_R_MAP = 8'b0100_0000,
      S_R_OUT = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic               is_load_ff, is_load_in;
   logic               second_ff, second_in;
   logic [IDX_W-1:0]   first_ff, first_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [VAL_W-1:0]   match_ff, match_in;
   logic [VAL_W-1:0]   repl_ff, repl_in;
   logic [BLK_W-1:0]   cur_blk_ff, cur_blk_in;
   logic [OFS_W-1:0]   idx_ff, idx_in;
   logic [VAL_W-1:0]   ent_ff, ent_in;
   logic [VAL_W-1:0]   e_ff, e_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic [VAL_W-1:0]   elem_mem [NUM_ELEMS];
   logic [VAL_W-1:0]   elem_q_ff;
   logic               elem_re;
   logic               elem_we;
   logic [IDX_W-1:0]   elem_addr;
   logic [VAL_W-1:0]   elem_wdata;

   rmp_req_type        rmp_req;
   logic [VAL_W-1:0]   rmp_data;

   logic               req_xfer;
   logic               rsp_xfer;
   logic [BLK_W-1:0]   lb, rb, req_lb, req_rb;
   logic [IDX_W-1:0]   cur_idx;
   logic [VAL_W-1:0]   mapped;
   logic               in_rng;

   rvr_remap_store u_remap (
      .clock   (clock),
      .reset   (reset),
      .req     (rmp_req),
      .rd_data (rmp_data)
   );

   // element memory
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_addr] <= elem_wdata;
      end
      if (elem_re) begin
         elem_q_ff <= elem_mem[elem_addr];
      end
   end

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_index  = rsp_index_ff;
   assign rsp_chan.read_value  = rsp_value_ff;

   assign lb      = first_ff[IDX_W-1:OFS_W];
   assign rb      = last_ff[IDX_W-1:OFS_W];
   assign req_lb  = req_chan.first_index[IDX_W-1:OFS_W];
   assign req_rb  = req_chan.last_index[IDX_W-1:OFS_W];
   assign cur_idx = {cur_blk_ff, idx_ff};
   assign mapped  = (e_ff > MAX_VAL) ? e_ff : rmp_data;
   assign in_rng  = !is_load_ff && (cur_idx >= first_ff) && (cur_idx <= last_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      is_load_in   = is_load_ff;
      second_in    = second_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      match_in     = match_ff;
      repl_in      = repl_ff;
      cur_blk_in   = cur_blk_ff;
      idx_in       = idx_ff;
      ent_in       = ent_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      elem_re      = 1'b0;
      elem_we      = 1'b0;
      elem_addr    = cur_idx;
      elem_wdata   = mapped;
      rmp_req      = '0;
      rmp_req.blk  = cur_blk_ff;
      rmp_req.ent  = ent_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               first_in   = req_chan.first_index;
               last_in    = req_chan.last_index;
               match_in   = req_chan.match_value;
               repl_in    = req_chan.new_value;
               second_in  = 1'b0;
               idx_in     = '0;
               ent_in     = '0;
               is_load_in = (req_chan.kind == KIND_LOAD);
               if (req_chan.kind == KIND_LOAD) begin
                  if (req_chan.new_value inside {[7'd1:MAX_VAL]}) begin
                     cur_blk_in = req_lb;
                     state_in   = S_E_RD;
                  end
               end else if (req_chan.kind == KIND_REPLACE) begin
                  if ((req_chan.match_value inside {[7'd1:MAX_VAL]}) &&
                      (req_chan.new_value inside {[7'd1:MAX_VAL]}) &&
                      req_chan.first_index <= req_chan.last_index) begin
                     if ({1'b0, req_rb} > ({1'b0, req_lb} + (BLK_W+1)'(1))) begin
                        cur_blk_in = req_lb + BLK_W'(1);
                        state_in   = S_B_RD;
                     end else begin
                        cur_blk_in = req_lb;
                        state_in   = S_E_RD;
                     end
                  end
               end else if (req_chan.kind == KIND_READ) begin
                  elem_re   = 1'b1;
                  elem_addr = req_chan.first_index;
                  state_in  = S_R_MAP;
               end
            end
         end
         // flush walk: read element, look it up, write it back
         S_E_RD: begin
            elem_re  = 1'b1;
            state_in = S_E_MAP;
         end
         S_E_MAP: begin
            e_in        = elem_q_ff;
            rmp_req.rd_en = 1'b1;
            rmp_req.ent = elem_q_ff;
            state_in    = S_E_WR;
         end
         S_E_WR: begin
            elem_we = 1'b1;
            if ((in_rng && mapped == match_ff) || (is_load_ff && cur_idx == first_ff)) begin
               elem_wdata = repl_ff;
            end
            if (idx_ff == LAST_OFS) begin
               rmp_req.clear_valid = 1'b1;
               idx_in = '0;
               if (!is_load_ff && !second_ff && rb != lb) begin
                  second_in  = 1'b1;
                  cur_blk_in = rb;
                  state_in   = S_E_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               idx_in   = idx_ff + OFS_W'(1);
               state_in = S_E_RD;
            end
         end
         // inner block table rewrite
         S_B_RD: begin
            rmp_req.rd_en = 1'b1;
            state_in      = S_B_WR;
         end
         S_B_WR: begin
            rmp_req.wr_en = 1'b1;
            rmp_req.wdata = (rmp_data == match_ff) ? repl_ff : rmp_data;
            if (ent_ff == MAX_VAL) begin
               rmp_req.set_valid = 1'b1;
               ent_in = '0;
               if (cur_blk_ff + BLK_W'(1) == rb) begin
                  cur_blk_in = lb;
                  state_in   = S_E_RD;
               end else begin
                  cur_blk_in = cur_blk_ff + BLK_W'(1);
                  state_in   = S_B_RD;
               end
            end else begin
               ent_in   = ent_ff + VAL_W'(1);
               state_in = S_B_RD;
            end
         end
         // element read
         S_R_MAP: begin
            e_in          = elem_q_ff;
            rmp_req.rd_en = 1'b1;
            rmp_req.blk   = lb;
            rmp_req.ent   = elem_q_ff;
            state_in      = S_R_OUT;
         end
         S_R_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = first_ff;
               rsp_value_in = (e_ff > MAX_VAL) ? '0 : rmp_data;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_load_ff   <= is_load_in;
      second_ff    <= second_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      match_ff     <= match_in;
      repl_ff      <= repl_in;
      cur_blk_ff   <= cur_blk_in;
      idx_ff       <= idx_in;
      ent_ff       <= ent_in;
      e_ff         <= e_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   // checks
   `RVR_ASSERT_IMPL(a_rsp_from_read, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_R_OUT))
   `RVR_ASSERT_NEVER(a_one_mem_write, clock, reset, rmp_req.wr_en && elem_we)
   `RVR_ASSERT_IMPL(a_inner_block, clock, reset, state_ff == S_B_WR, cur_blk_ff > lb && cur_blk_ff < rb)

endmodule

// File: tb/sv/range_value_replace_blocked_unit_tb.sv
// ----------------------------------------------------------------------------
// range_value_replace_blocked_unit_tb
// Self-checking bench for the blocked range value replace unit. A directed
// table covers extremes and ignored items, then random loads, replaces and
// reads follow. Each read result is checked against its row's typed value if
// set, else an in-bench model of the element store and per-block remap tables.
// ----------------------------------------------------------------------------
module range_value_replace_blocked_unit_tb;
   import rvr_pkg::*;

   localparam int ELEMS      = 4096;
   localparam int BLK_SIZE   = 64;
   localparam int BLOCKS     = ELEMS / BLK_SIZE;
   localparam int VMAX       = 100;
   localparam int RAND_ITEMS = 1000;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      kind_type         kind;
      logic [11:0]      first;
      logic [11:0]      last;
      logic [6:0]       match;
      logic [6:0]       newv;
   } item_t;

   typedef struct packed {
      logic [11:0] idx;
      logic [6:0]  val;
   } read_t;

   // directed row: typed value used when has_exp is set
   typedef struct packed {
      item_t      item;
      logic       has_exp;
      logic [6:0] exp_val;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rvr_req_if req_chan ();
   rvr_rsp_if rsp_chan ();

   range_value_replace_blocked_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   // model state
   logic [6:0] elem_mem [ELEMS];
   logic [6:0] remap_tbl [BLOCKS][VMAX+1];
   bit         loaded [ELEMS];
   int         loaded_list [$];
   read_t      reads_pending [$];
   logic [6:0] typed_vals [$];
   bit         typed_flags [$];

   int  mismatches = 0;
   int  cycles = 0;
   int  xfers_in = 0;
   bit  long_hold = 1'b0;

   // ------------------------------------------------------------------ model
   function automatic void remap_identity(int b);
      for (int v = 0; v <= VMAX; v++) remap_tbl[b][v] = 7'(v);
   endfunction

   function automatic void flush_blk(int b);
      for (int i = b * BLK_SIZE; i < (b + 1) * BLK_SIZE; i++)
         if (elem_mem[i] <= VMAX) elem_mem[i] = remap_tbl[b][elem_mem[i]];
      remap_identity(b);
   endfunction

   function automatic void patch_span(int lo, int hi, logic [6:0] m, logic [6:0] r);
      for (int i = lo; i <= hi; i++)
         if (elem_mem[i] == m) elem_mem[i] = r;
   endfunction

   function automatic void replace_range(int f, int l, logic [6:0] m, logic [6:0] r);
      int lb, rb;
      if (f > l) return;
      lb = f / BLK_SIZE;
      rb = l / BLK_SIZE;
      if (lb == rb) begin
         flush_blk(lb);
         patch_span(f, l, m, r);
         return;
      end
      for (int b = lb + 1; b < rb; b++)
         for (int v = 0; v <= VMAX; v++)
            if (remap_tbl[b][v] == m) remap_tbl[b][v] = r;
      flush_blk(lb);
      patch_span(f, (lb + 1) * BLK_SIZE - 1, m, r);
      flush_blk(rb);
      patch_span(rb * BLK_SIZE, l, m, r);
   endfunction

   function automatic bit val_ok(logic [6:0] v);
      return v >= 1 && v <= VMAX;
   endfunction

   // apply one accepted transfer; returns 1 with the expected read when one is due
   function automatic bit apply_item(item_t it, output read_t rd);
      logic [6:0] e;
      rd = '0;
      case (it.kind)
         KIND_LOAD: begin
            if (val_ok(it.newv)) begin
               flush_blk(it.first / BLK_SIZE);
               elem_mem[it.first] = it.newv;
            end
            return 1'b0;
         end
         KIND_REPLACE: begin
            if (val_ok(it.match) && val_ok(it.newv))
               replace_range(it.first, it.last, it.match, it.newv);
            return 1'b0;
         end
         KIND_READ: begin
            e = elem_mem[it.first];
            rd.idx = it.first;
            rd.val = (e <= VMAX) ? remap_tbl[it.first / BLK_SIZE][e] : 7'd0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   initial begin
      for (int i = 0; i < ELEMS; i++) elem_mem[i] = '0;
      for (int b = 0; b < BLOCKS; b++) remap_identity(b);
   end

   // ------------------------------------------------- monitor and checking
   always @(posedge clock) begin
      item_t it;
      read_t rd;
      read_t got;
      if (!reset) begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("range_value_replace_blocked_unit verification failed");
            $finish;
         end
         // input transfer: update the model
         if (req_chan.valid && req_chan.ready) begin
            it.kind  = kind_type'(req_chan.kind);
            it.first = req_chan.first_index;
            it.last  = req_chan.last_index;
            it.match = req_chan.match_value;
            it.newv  = req_chan.new_value;
            xfers_in <= xfers_in + 1;
            if (apply_item(it, rd)) begin
               if (typed_flags.size() != 0 && typed_flags.pop_front())
                  rd.val = typed_vals.pop_front();
               reads_pending.push_back(rd);
            end
            if (it.kind == KIND_LOAD && val_ok(it.newv) && !loaded[it.first]) begin
               loaded[it.first] = 1'b1;
               loaded_list.push_back(it.first);
            end
         end
         // result transfer: compare with oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.idx = rsp_chan.read_index;
            got.val = rsp_chan.read_value;
            if (reads_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result idx=%0d val=%0d", got.idx, got.val);
            end else begin
               rd = reads_pending.pop_front();
               if (rd !== got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp idx=%0d val=%0d got idx=%0d val=%0d",
                              rd.idx, rd.val, got.idx, got.val);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------ receiver
   initial begin
      int mode;
      int hold;
      rsp_chan.ready = 1'b0;
      mode = 0;
      forever begin
         @(negedge clock);
         // one long hold-off so the unit backs up and stalls its input
         if (!long_hold && xfers_in > 150) begin
            long_hold = 1'b1;
            rsp_chan.ready = 1'b0;
            hold = 600;
            while (hold > 0) begin
               @(negedge clock);
               hold--;
            end
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_chan.ready = 1'b1;
            1: rsp_chan.ready = $urandom_range(0, 1);
            2: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready = (cycles % 7) < 3;
         endcase
      end
   end

   // -------------------------------------------------------------- sender
   int burst_left = 0;

   task automatic send_item(item_t it);
      req_chan.kind        = it.kind;
      req_chan.first_index = it.first;
      req_chan.last_index  = it.last;
      req_chan.match_value = it.match;
      req_chan.new_value   = it.newv;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      // end of burst: drop valid for a random gap
      if (burst_left == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [11:0] pick_index();
      if ($urandom_range(0, 9) < 7) return 12'($urandom_range(0, 383));
      return 12'($urandom_range(0, ELEMS - 1));
   endfunction

   function automatic logic [6:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return 7'($urandom_range(1, 6));
      if (r < 19) return 7'($urandom_range(1, VMAX));
      return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(VMAX + 1, 127));
   endfunction

   function automatic item_t random_item(ref int full_runs);
      item_t it;
      int r;
      int span;
      it = '0;
      r = $urandom_range(0, 99);
      if (r < 25 || loaded_list.size() == 0) begin
         it.kind  = KIND_LOAD;
         it.first = pick_index();
         it.last  = 12'($urandom());
         it.match = 7'($urandom());
         it.newv  = pick_value();
      end else if (r < 62) begin
         it.kind  = KIND_REPLACE;
         it.first = pick_index();
         it.match = pick_value();
         it.newv  = pick_value();
         span = $urandom_range(0, 99);
         if (span < 75)
            it.last = 12'(((int'(it.first) + $urandom_range(0, 200)) > ELEMS - 1) ?
                          ELEMS - 1 : int'(it.first) + $urandom_range(0, 200));
         else if (span < 90)
            it.last = 12'($urandom_range(it.first, ELEMS - 1));
         else if (span < 97 || full_runs >= 6)
            it.last = 12'($urandom_range(0, it.first));
         else begin
            full_runs++;
            it.first = '0;
            it.last  = 12'(ELEMS - 1);
         end
      end else if (r < 96) begin
         it.kind  = KIND_READ;
         it.first = 12'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
         it.last  = 12'($urandom());
         it.match = 7'($urandom());
         it.newv  = 7'($urandom());
      end else begin
         it = item_t'({KIND_UNUSED, 12'($urandom()), 12'($urandom()), 7'($urandom()),
                       7'($urandom())});
      end
      return it;
   endfunction

   function automatic row_t mk(kind_type k, int f, int l, int m, int n, bit he, int ev);
      row_t r;
      r.item.kind = k;
      r.item.first = 12'(f);
      r.item.last = 12'(l);
      r.item.match = 7'(m);
      r.item.newv = 7'(n);
      r.has_exp = he;
      r.exp_val = 7'(ev);
      return r;
   endfunction

   initial begin
      row_t rows [$];
      item_t it;
      int full_runs;
      full_runs = 0;
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_LOAD;
      req_chan.first_index = '0;
      req_chan.last_index = '0;
      req_chan.match_value = '0;
      req_chan.new_value = '0;

      // directed table: extremes, ignored items, in-block and cross-block ranges
      rows.push_back(mk(KIND_LOAD,    0,    0,    0,   1, 0, 0));
      rows.push_back(mk(KIND_LOAD,    4095, 0,    0,   100, 0, 0));
      rows.push_back(mk(KIND_READ,    0,    0,    0,   0, 1, 1));
      rows.push_back(mk(KIND_READ,    4095, 4095, 127, 127, 1, 100));
      rows.push_back(mk(KIND_LOAD,    4095, 0,    0,   0, 0, 0));
      rows.push_back(mk(KIND_LOAD,    4095, 0,    0,   127, 0, 0));
      rows.push_back(mk(KIND_READ,    4095, 0,    0,   0, 1, 100));
      rows.push_back(mk(KIND_LOAD,    64,   0,    0,   5, 0, 0));
      rows.push_back(mk(KIND_LOAD,    63,   0,    0,   7, 0, 0));
      rows.push_back(mk(KIND_REPLACE, 0,    4095, 100, 1, 0, 0));
      rows.push_back(mk(KIND_READ,    4095, 0,    0,   0, 1, 1));
      rows.push_back(mk(KIND_REPLACE, 100,  50,   1,   9, 0, 0));
      rows.push_back(mk(KIND_REPLACE, 0,    4095, 0,   9, 0, 0));
      rows.push_back(mk(KIND_REPLACE, 0,    4095, 1,   127, 0, 0));
      rows.push_back(mk(KIND_REPLACE, 0,    4095, 127, 9, 0, 0));
      rows.push_back(mk(KIND_READ,    0,    0,    0,   0, 1, 1));
      rows.push_back(mk(KIND_LOAD,    0,    0,    0,   7, 0, 0));
      rows.push_back(mk(KIND_LOAD,    0,    0,    0,   0, 0, 0));
      rows[$].item = item_t'({KIND_UNUSED, 12'hfff, 12'hfff, 7'h7f, 7'h7f});
      // in-block range must start at its first index
      rows.push_back(mk(KIND_REPLACE, 1,    63,   7,   9, 0, 0));
      rows.push_back(mk(KIND_READ,    0,    0,    0,   0, 1, 7));
      rows.push_back(mk(KIND_READ,    63,   0,    0,   0, 1, 9));
      rows.push_back(mk(KIND_REPLACE, 10,   200,  5,   3, 0, 0));
      rows.push_back(mk(KIND_READ,    64,   0,    0,   0, 0, 0));
      rows.push_back(mk(KIND_REPLACE, 0,    4095, 1,   64, 0, 0));
      rows.push_back(mk(KIND_READ,    4095, 0,    0,   0, 0, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         if (rows[i].item.kind == KIND_READ) begin
            typed_flags.push_back(rows[i].has_exp);
            if (rows[i].has_exp) typed_vals.push_back(rows[i].exp_val);
         end
         send_item(rows[i].item);
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         it = random_item(full_runs);
         send_item(it);
      end
      req_chan.valid = 1'b0;

      // drain outstanding results, then let trailing work settle
      while (reads_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("range_value_replace_blocked_unit verification clean");
      else
         $display("range_value_replace_blocked_unit verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rvr_pkg.sv
hw/rtl/rvr_req_if.sv
hw/rtl/rvr_rsp_if.sv
hw/rtl/rvr_remap_store.sv
hw/rtl/range_value_replace_blocked_unit.sv
tb/sv/range_value_replace_blocked_unit_tb.sv
